// ===== hdl/fbe_pkg.sv =====
package fbe_pkg;

    localparam int PHASE_COUNT = 8;

    // shared divider: |level gap| or |product| * 257 over an 8 or 12 bit divisor
    localparam int DIV_NW = 25;
    localparam int DIV_DW = 12;
    localparam int DIV_CW = $clog2(DIV_NW);

    // x / 10 == (x * 52429) >> 19 for every 16 bit x
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_PHASE = 2'd1;
    localparam logic [1:0] MODE_POS_A = 2'd2;
    localparam logic [1:0] MODE_POS_B = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_LEVELS = 2'd1;
    localparam logic [1:0] CFG_POINTS = 2'd2;

    // what the decide cycle found for the item
    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_PDIV = 2'd1;
    localparam logic [1:0] KIND_EDIR = 2'd2;
    localparam logic [1:0] KIND_ESEG = 2'd3;

    localparam logic STEP_FROM_DIV = 1'b0;
    localparam logic STEP_FROM_MUL = 1'b1;

    typedef struct packed {
        logic load_in;
        logic decide;
        logic mul;
        logic scale;
        logic div_start;
        logic itgt;
        logic step10;
        logic step;
        logic step_src;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       div_busy;
    } t_status;

endpackage

// ===== hdl/fbe_div.sv =====
module fbe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fbe_pkg::DIV_NW-1:0]  i_num,
    input  logic [fbe_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_busy,
    output logic [fbe_pkg::DIV_NW-1:0]  o_quo
);
    import fbe_pkg::*;

    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb begin
        shifted = {r_rem, r_quo[DIV_NW-1]};
        ge      = shifted >= {1'b0, i_den};
        diff    = shifted - {1'b0, i_den};
        n_rem   = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        n_quo   = {r_quo[DIV_NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/fbe_datapath.sv =====
module fbe_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_wdata,
    input  logic               i_note_boundary,
    input  logic [7:0]         i_phase_number,
    input  logic [7:0]         i_env_pos_a,
    input  logic [7:0]         i_env_pos_b,
    input  logic [15:0]        i_current_level,
    input  fbe_pkg::t_cmd      i_cmd,
    output fbe_pkg::t_status   o_status,
    output logic               o_target_written,
    output logic [15:0]        o_target_level,
    output logic signed [13:0] o_step_size,
    output logic               o_snap_current,
    output logic               o_phase_cleared
);
    import fbe_pkg::*;

    // configuration and state
    logic [1:0]  r_mode;
    logic [63:0] r_levels;
    logic [63:0] r_points;
    logic [7:0]  r_last_pos;

    // item registers
    logic        r_boundary;
    logic [7:0]  r_phase;
    logic [7:0]  r_pos_a;
    logic [7:0]  r_pos_b;
    logic [15:0] r_current;

    // working registers
    logic [1:0]          r_kind;
    logic                r_written;
    logic                r_snap;
    logic                r_clear;
    logic [15:0]         r_target;
    logic [13:0]         r_step;
    logic [7:0]          r_dpos;
    logic signed [8:0]   r_dlvl;
    logic [15:0]         r_base;
    logic signed [17:0]  r_prod;
    logic [DIV_NW-1:0]   r_num;
    logic [DIV_DW-1:0]   r_den;
    logic                r_neg;
    logic                r_sneg;
    logic                r_eqz;
    logic [31:0]         r_mulq;

    // output register
    logic        r_o_written;
    logic [15:0] r_o_target;
    logic [13:0] r_o_step;
    logic        r_o_snap;
    logic        r_o_clear;

    logic [7:0] lvl [PHASE_COUNT];
    logic [7:0] pts [PHASE_COUNT];

    logic               phase_act;
    logic               env_act;
    logic [7:0]         pos;
    logic [2:0]         ph_idx;
    logic [7:0]         ph_time;
    logic [15:0]        ph_target;
    logic signed [16:0] ph_diff;
    logic [15:0]        ph_mag;
    logic [DIV_DW-1:0]  time10;
    logic [PHASE_COUNT-1:0] hit;
    logic [2:0]         seg;
    logic [2:0]         seg_lo;
    logic               found;

    logic               div_busy;
    logic [DIV_NW-1:0]  div_quo;

    logic [15:0]        prod_mag;
    logic signed [17:0] q_signed;
    logic signed [17:0] tgt_sum;
    logic signed [16:0] s_diff;
    logic [15:0]        s_mag;
    logic [12:0]        stp_mag;
    logic               stp_neg;
    logic               stp_eq;
    logic [13:0]        stp_ext;
    logic [13:0]        stp_val;

    always_comb begin
        for (int k = 0; k < PHASE_COUNT; k++) begin
            lvl[k] = r_levels[8*k +: 8];
            pts[k] = r_points[8*k +: 8];
        end
    end

    // decide: which kind of update this item causes
    always_comb begin
        phase_act = (r_mode == MODE_PHASE) && r_boundary && (r_phase != r_last_pos);
        env_act   = ((r_mode == MODE_POS_A) && (r_pos_a != r_last_pos)) ||
                    ((r_mode == MODE_POS_B) && (r_pos_b != r_last_pos));
        pos       = (r_mode == MODE_POS_A) ? r_pos_a : r_pos_b;

        // phase 8 wraps to index 7
        ph_idx    = r_phase[2:0] - 3'd1;
        ph_time   = pts[ph_idx];
        ph_target = {lvl[ph_idx], lvl[ph_idx]};
        ph_diff   = $signed({1'b0, ph_target}) - $signed({1'b0, r_current});
        ph_mag    = ph_diff[16] ? 16'(-ph_diff) : ph_diff[15:0];
        time10    = {1'b0, ph_time, 3'b000} + {3'b000, ph_time, 1'b0};

        for (int k = 0; k < PHASE_COUNT; k++) begin
            hit[k] = pos <= pts[k];
        end
        // first breakpoint at or above the position picks the segment
        seg = 3'd1;
        for (int k = PHASE_COUNT - 1; k >= 1; k--) begin
            if (hit[k]) begin
                seg = 3'(k);
            end
        end
        seg_lo = seg - 3'd1;
        found  = |hit[PHASE_COUNT-1:1];
    end

    always_comb begin
        prod_mag = r_prod[17] ? 16'(-r_prod) : r_prod[15:0];
        q_signed = r_neg ? -$signed({2'b00, div_quo[15:0]})
                         : $signed({2'b00, div_quo[15:0]});
        tgt_sum  = q_signed + $signed({2'b00, r_base});
        s_diff   = $signed({1'b0, r_target}) - $signed({1'b0, r_current});
        s_mag    = s_diff[16] ? 16'(-s_diff) : s_diff[15:0];

        if (i_cmd.step_src == STEP_FROM_DIV) begin
            stp_mag = div_quo[12:0];
            stp_neg = r_neg;
            stp_eq  = 1'b0;
        end else begin
            stp_mag = r_mulq[RECIP10_SHIFT +: 13];
            stp_neg = r_sneg;
            stp_eq  = r_eqz;
        end
        stp_ext = {1'b0, stp_mag};
        // a step that truncates to zero moves by +1 whatever the direction
        if (stp_eq) begin
            stp_val = '0;
        end else if (stp_mag == '0) begin
            stp_val = 14'd1;
        end else if (stp_neg) begin
            stp_val = -stp_ext;
        end else begin
            stp_val = stp_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_levels   <= '0;
            r_points   <= '0;
            r_last_pos <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                    CFG_LEVELS: r_levels <= i_cfg_wdata;
                    CFG_POINTS: r_points <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.decide && phase_act) begin
                r_last_pos <= r_phase;
            end else if (i_cmd.decide && env_act) begin
                r_last_pos <= pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_boundary <= i_note_boundary;
            r_phase    <= i_phase_number;
            r_pos_a    <= i_env_pos_a;
            r_pos_b    <= i_env_pos_b;
            r_current  <= i_current_level;
        end

        if (i_cmd.decide) begin
            r_kind    <= KIND_DONE;
            r_written <= 1'b0;
            r_snap    <= 1'b0;
            r_clear   <= 1'b0;
            r_target  <= '0;
            r_step    <= '0;
            if (phase_act) begin
                if (r_phase > 8'(PHASE_COUNT)) begin
                    r_clear <= 1'b1;
                end else if (r_phase != 8'd0) begin
                    r_written <= 1'b1;
                    r_target  <= ph_target;
                    if (ph_diff == '0) begin
                        r_step <= '0;
                    end else if (ph_time == 8'd0) begin
                        r_snap <= 1'b1;
                    end else begin
                        r_kind <= KIND_PDIV;
                        r_num  <= DIV_NW'(ph_mag);
                        r_neg  <= ph_diff[16];
                        r_den  <= time10;
                    end
                end
            end else if (env_act) begin
                r_written <= 1'b1;
                if (hit[0]) begin
                    r_kind   <= KIND_EDIR;
                    r_target <= {lvl[0], lvl[0]};
                end else if (!found) begin
                    r_kind   <= KIND_EDIR;
                    r_target <= {lvl[PHASE_COUNT-1], lvl[PHASE_COUNT-1]};
                end else begin
                    r_kind <= KIND_ESEG;
                    r_dpos <= pos - pts[seg_lo];
                    r_dlvl <= $signed({1'b0, lvl[seg]}) - $signed({1'b0, lvl[seg_lo]});
                    r_den  <= DIV_DW'(pts[seg] - pts[seg_lo]);
                    r_base <= {lvl[seg_lo], lvl[seg_lo]};
                end
            end
        end

        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_dpos}) * r_dlvl;
        end

        // magnitude times 257
        if (i_cmd.scale) begin
            r_num <= DIV_NW'({prod_mag, 8'h00}) + DIV_NW'(prod_mag);
            r_neg <= r_prod[17];
        end

        if (i_cmd.itgt) begin
            r_target <= tgt_sum[15:0];
        end

        if (i_cmd.step10) begin
            r_sneg  <= s_diff[16];
            r_eqz   <= s_diff == '0;
            r_mulq  <= s_mag * RECIP10;
        end

        if (i_cmd.step) begin
            r_step <= stp_val;
        end

        if (i_cmd.out_load) begin
            r_o_written <= r_written;
            r_o_target  <= r_target;
            r_o_step    <= r_step;
            r_o_snap    <= r_snap;
            r_o_clear   <= r_clear;
        end
    end

    fbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign o_status.kind     = r_kind;
    assign o_status.div_busy = div_busy;

    assign o_target_written = r_o_written;
    assign o_target_level   = r_o_target;
    assign o_step_size      = $signed(r_o_step);
    assign o_snap_current   = r_o_snap;
    assign o_phase_cleared  = r_o_clear;

endmodule

// ===== hdl/fbe_ctrl.sv =====
module fbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fbe_pkg::t_status i_status,
    output fbe_pkg::t_cmd    o_cmd
);
    import fbe_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_ROUTE  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_SCALE  = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_ITGT   = 4'd7;
    localparam logic [3:0] S_STEP10 = 4'd8;
    localparam logic [3:0] S_STEPM  = 4'd9;
    localparam logic [3:0] S_STEPD  = 4'd10;
    localparam logic [3:0] S_FINISH = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step_src = STEP_FROM_DIV;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_ROUTE;
            end
            S_ROUTE: begin
                case (i_status.kind)
                    KIND_PDIV: n_state = S_DSTART;
                    KIND_EDIR: n_state = S_STEP10;
                    KIND_ESEG: n_state = S_MUL;
                    default:   n_state = S_FINISH;
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = (i_status.kind == KIND_ESEG) ? S_ITGT : S_STEPD;
                end
            end
            S_ITGT: begin
                o_cmd.itgt = 1'b1;
                n_state    = S_STEP10;
            end
            S_STEP10: begin
                o_cmd.step10 = 1'b1;
                n_state      = S_STEPM;
            end
            S_STEPM: begin
                o_cmd.step     = 1'b1;
                o_cmd.step_src = STEP_FROM_MUL;
                n_state        = S_FINISH;
            end
            S_STEPD: begin
                o_cmd.step     = 1'b1;
                o_cmd.step_src = STEP_FROM_DIV;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/fader_breakpoint_envelope.sv =====
// fader automation for one mixer track, one item per sequencer tick.
// input channel (i_in_valid / o_in_ready) takes the tick: note boundary,
// phase number, envelope positions a and b and the fader's present level.
// output channel (o_out_valid / i_out_ready) returns exactly one item per
// input item: target written flag, target level, signed step, snap and
// phase-cleared flags.
// configuration uses a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata):
// index 0 fader mode, 1 level table, 2 breakpoint table; write while idle.
// from input accept the item passes the decide and route states; an item
// that decide settles goes straight to finish, a target at or past the end
// breakpoints first takes the step by reciprocal multiply, a phase step runs
// the shared radix-2 divider, and an interpolated envelope target multiplies,
// scales, divides, adds the base and takes the reciprocal step; one item
// is worked on at a time and the next is taken after finish loads the output.
// the result sits in an output register, so a stalled receiver only holds
// the block once a second result is ready to be registered.
// reset clears mode, both tables, the last position and all handshake state.
module fader_breakpoint_envelope (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_note_boundary,
    input  logic [7:0]         i_phase_number,
    input  logic [7:0]         i_env_pos_a,
    input  logic [7:0]         i_env_pos_b,
    input  logic [15:0]        i_current_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_target_written,
    output logic [15:0]        o_target_level,
    output logic signed [13:0] o_step_size,
    output logic               o_snap_current,
    output logic               o_phase_cleared
);
    import fbe_pkg::*;

    t_cmd    cmd;
    t_status status;

    fbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fbe_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_note_boundary  (i_note_boundary),
        .i_phase_number   (i_phase_number),
        .i_env_pos_a      (i_env_pos_a),
        .i_env_pos_b      (i_env_pos_b),
        .i_current_level  (i_current_level),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_target_written (o_target_written),
        .o_target_level   (o_target_level),
        .o_step_size      (o_step_size),
        .o_snap_current   (o_snap_current),
        .o_phase_cleared  (o_phase_cleared)
    );

endmodule
